// ----- rtl/fcrs_pkg.sv -----
// fcrs_pkg: shared constants for the fat32 chain read segmenter
// used by the top level, the table ram user and the port checker
`timescale 1ns / 1ps

package fcrs_pkg;

   localparam int DEF_FAT_ENTRIES  = 4096;
   localparam int DEF_MAX_SEGMENTS = 64;

   localparam logic [27:0] END_OF_CHAIN       = 28'hFFF_FFF8;
   localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

   // configuration register indexes
   localparam logic [2:0] REG_SECTOR_BYTES_LOG2    = 3'd0;
   localparam logic [2:0] REG_CLUSTER_SECTORS_LOG2 = 3'd1;
   localparam logic [2:0] REG_RESERVED_SECTORS     = 3'd2;
   localparam logic [2:0] REG_FAT_LENGTH_SECTORS   = 3'd3;
   localparam logic [2:0] REG_FAT_COPIES           = 3'd4;

   localparam logic [3:0]  RST_SECTOR_BYTES_LOG2    = 4'd9;
   localparam logic [2:0]  RST_CLUSTER_SECTORS_LOG2 = 3'd0;
   localparam logic [15:0] RST_RESERVED_SECTORS     = 16'd32;
   localparam logic [31:0] RST_FAT_LENGTH_SECTORS   = 32'd0;
   localparam logic [2:0]  RST_FAT_COPIES           = 3'd2;

   localparam logic [3:0] SECTOR_LOG2_MIN = 4'd9;
   localparam logic [3:0] SECTOR_LOG2_MAX = 4'd12;

   // request action codes
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CHAIN_END = 2'd1;
   localparam logic [1:0] STATUS_SEG_LIMIT = 2'd2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // request tdata layout
   localparam int REQ_DATA_W = 152;
   localparam int RQ_IDX_LO  = 0;
   localparam int RQ_VAL_LO  = 12;
   localparam int RQ_CLU_LO  = 44;
   localparam int RQ_LEN_LO  = 56;
   localparam int RQ_POS_LO  = 88;
   localparam int RQ_CNT_LO  = 119;

   // response tdata layout
   localparam int RSP_DATA_W = 80;
   localparam int RS_SEC_LO  = 0;
   localparam int RS_OFF_LO  = 32;
   localparam int RS_LEN_LO  = 51;
   localparam int RS_STS_LO  = 71;

   localparam int ENTRY_W = 28;

endpackage

// ----- rtl/fcrs_ram.sv -----
// fcrs_ram: generic single write port, single read port ram
// registered read data; no dependencies
`timescale 1ns / 1ps

module fcrs_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fat32_chain_read_segmenter_top.sv -----
// Load requests with an in-range index write one FAT entry in the cycle they are taken. A read
// request holds the input off after it is taken until its last result is handed on: a setup
// state, a read and a check state per skipped cluster, one state to enter the segment loop and
// a segment, check and emit state per segment, the final segment skipping the check (unless a
// table read finds the chain end), plus any wait for a free output register. An empty request
// or an overlong skip goes from setup straight to its single result. Every chain step is one
// read of the table ram, whose registered read data is examined in the following cycle before
// the next step starts. One request is in flight at a time; a finished result may still wait
// in the output register while the next request is taken. The FAT table has no reset: entries
// hold whatever was last loaded.
// fat32_chain_read_segmenter_top: chain walk control, segment math, config and output stage
// depends on fcrs_pkg and fcrs_ram
`timescale 1ns / 1ps

module fat32_chain_read_segmenter_top
   import fcrs_pkg::*;
#(
   parameter int FAT_ENTRIES  = DEF_FAT_ENTRIES,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index, entry_value, start_cluster, file_length, byte_position, byte_count
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic                  req_tuser,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sector_number, offset_in_cluster, segment_length, status
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW     = $clog2(FAT_ENTRIES);
   localparam int SKIP_W = $clog2(FAT_ENTRIES + 1);
   localparam int K_W    = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_PREP     = 7'b0000010,
      ST_SKIP_RD  = 7'b0000100,
      ST_SKIP_CHK = 7'b0001000,
      ST_SEG      = 7'b0010000,
      ST_SEG_CHK  = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [3:0]  sb_log2_ff;
   logic [2:0]  cs_log2_ff;
   logic [15:0] reserved_ff;
   logic [31:0] fat_len_ff;
   logic [2:0]  copies_ff;

   // request fields
   logic [11:0] rq_idx;
   logic [31:0] rq_val;
   logic [11:0] rq_clu;
   logic [31:0] rq_flen;
   logic [30:0] rq_pos;
   logic [30:0] rq_cnt;
   logic        req_acc;

   // working registers
   logic [27:0]       cur_ff, cur_in;
   logic [31:0]       flen_ff, flen_in;
   logic [30:0]       pos_ff, pos_in;
   logic [30:0]       cnt_ff, cnt_in;
   logic [31:0]       remain_ff, remain_in;
   logic [18:0]       off_ff, off_in;
   logic [4:0]        cls_ff, cls_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic [K_W-1:0]    seg_cnt_ff, seg_cnt_in;
   logic [31:0]       data_start_ff, data_start_in;
   logic [31:0]       pend_sec_ff, pend_sec_in;
   logic [18:0]       pend_off_ff, pend_off_in;
   logic [19:0]       pend_len_ff, pend_len_in;
   logic [1:0]        pend_sts_ff, pend_sts_in;
   logic              pend_last_ff, pend_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   // ram
   logic              wr_en;
   logic [31:0]       wr_idx_ext;
   logic              rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic              rd_eoc;

   // setup math
   logic [3:0]  sb_sat;
   logic [4:0]  cls_calc;
   logic [30:0] skip_calc;
   logic [18:0] off_mask;
   logic [31:0] diff;
   logic [31:0] remain_calc;
   logic [31:0] prod;

   // segment math
   logic [19:0] csize;
   logic [19:0] avail;
   logic [19:0] seg_len;
   logic [31:0] remain_next;
   logic [31:0] seg_sec;
   logic        cur_ok;
   logic        seg_limit;
   logic        out_free;

   assign rq_idx  = req_tdata[RQ_IDX_LO +: 12];
   assign rq_val  = req_tdata[RQ_VAL_LO +: 32];
   assign rq_clu  = req_tdata[RQ_CLU_LO +: 12];
   assign rq_flen = req_tdata[RQ_LEN_LO +: 32];
   assign rq_pos  = req_tdata[RQ_POS_LO +: 31];
   assign rq_cnt  = req_tdata[RQ_CNT_LO +: 31];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign wr_idx_ext = 32'(rq_idx);
   assign wr_en      = req_acc && (req_tuser == ACTION_LOAD) && (wr_idx_ext < 32'(FAT_ENTRIES));
   assign cur_ok     = 32'(cur_ff) < 32'(FAT_ENTRIES);
   assign rd_eoc     = rd_data >= END_OF_CHAIN;

   fcrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FAT_ENTRIES)
   ) u_fat_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_ext[AW-1:0]),
      .wr_data (rq_val[ENTRY_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (cur_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      if (sb_log2_ff < SECTOR_LOG2_MIN) begin
         sb_sat = SECTOR_LOG2_MIN;
      end else if (sb_log2_ff > SECTOR_LOG2_MAX) begin
         sb_sat = SECTOR_LOG2_MAX;
      end else begin
         sb_sat = sb_log2_ff;
      end
      cls_calc  = 5'(sb_sat) + 5'(cs_log2_ff);
      skip_calc = pos_ff >> cls_calc;
      off_mask  = 19'((20'(1) << cls_calc) - 20'(1));
      diff      = flen_ff - 32'(pos_ff);
      if (32'(pos_ff) >= flen_ff) begin
         remain_calc = '0;
      end else if (32'(cnt_ff) < diff) begin
         remain_calc = 32'(cnt_ff);
      end else begin
         remain_calc = diff;
      end
      prod = fat_len_ff * 32'(copies_ff);

      csize       = 20'(1) << cls_ff;
      avail       = csize - 20'(off_ff);
      seg_len     = (remain_ff < 32'(avail)) ? remain_ff[19:0] : avail;
      remain_next = remain_ff - 32'(seg_len);
      seg_sec     = ((32'(cur_ff) - FIRST_DATA_CLUSTER) << cs_log2_ff) + data_start_ff;
      seg_limit   = (32'(seg_cnt_ff) + 32'd1) >= 32'(MAX_SEGMENTS);
      out_free    = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      flen_in       = flen_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      remain_in     = remain_ff;
      off_in        = off_ff;
      cls_in        = cls_ff;
      skip_in       = skip_ff;
      seg_cnt_in    = seg_cnt_ff;
      data_start_in = data_start_ff;
      pend_sec_in   = pend_sec_ff;
      pend_off_in   = pend_off_ff;
      pend_len_in   = pend_len_ff;
      pend_sts_in   = pend_sts_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == ACTION_READ)) begin
               cur_in   = 28'(rq_clu);
               flen_in  = rq_flen;
               pos_in   = rq_pos;
               cnt_in   = rq_cnt;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cls_in        = cls_calc;
            remain_in     = remain_calc;
            off_in        = pos_ff[18:0] & off_mask;
            data_start_in = 32'(reserved_ff) + prod;
            seg_cnt_in    = '0;
            pend_sec_in   = '0;
            pend_off_in   = '0;
            pend_len_in   = '0;
            pend_last_in  = 1'b1;
            if (remain_calc == '0) begin
               pend_sts_in = STATUS_OK;
               state_in    = ST_EMIT;
            end else if (32'(skip_calc) > 32'(FAT_ENTRIES)) begin
               pend_sts_in = STATUS_CHAIN_END;
               state_in    = ST_EMIT;
            end else begin
               skip_in  = SKIP_W'(skip_calc);
               state_in = ST_SKIP_RD;
            end
         end
         ST_SKIP_RD: begin
            if (skip_ff == '0) begin
               state_in = ST_SEG;
            end else if (!cur_ok) begin
               pend_sts_in = STATUS_CHAIN_END;
               state_in    = ST_EMIT;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SKIP_CHK;
            end
         end
         ST_SKIP_CHK: begin
            if (rd_eoc) begin
               pend_sts_in = STATUS_CHAIN_END;
               state_in    = ST_EMIT;
            end else begin
               cur_in   = rd_data;
               skip_in  = skip_ff - SKIP_W'(1);
               state_in = ST_SKIP_RD;
            end
         end
         ST_SEG: begin
            pend_sec_in  = seg_sec;
            pend_off_in  = off_ff;
            pend_len_in  = seg_len;
            remain_in    = remain_next;
            pend_last_in = 1'b1;
            if (remain_next == '0) begin
               pend_sts_in = STATUS_OK;
               state_in    = ST_EMIT;
            end else if (seg_limit) begin
               pend_sts_in = STATUS_SEG_LIMIT;
               state_in    = ST_EMIT;
            end else if (!cur_ok) begin
               pend_sts_in = STATUS_CHAIN_END;
               state_in    = ST_EMIT;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SEG_CHK;
            end
         end
         ST_SEG_CHK: begin
            state_in = ST_EMIT;
            if (rd_eoc) begin
               pend_sts_in  = STATUS_CHAIN_END;
               pend_last_in = 1'b1;
            end else begin
               pend_sts_in  = STATUS_OK;
               pend_last_in = 1'b0;
               cur_in       = rd_data;
               seg_cnt_in   = seg_cnt_ff + K_W'(1);
               off_in       = '0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[RS_SEC_LO +: 32] = pend_sec_ff;
               rsp_data_in[RS_OFF_LO +: 19] = pend_off_ff;
               rsp_data_in[RS_LEN_LO +: 20] = pend_len_ff;
               rsp_data_in[RS_STS_LO +: 2]  = pend_sts_ff;
               rsp_last_in  = pend_last_ff;
               state_in     = pend_last_ff ? ST_IDLE : ST_SEG;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sb_log2_ff   <= RST_SECTOR_BYTES_LOG2;
         cs_log2_ff   <= RST_CLUSTER_SECTORS_LOG2;
         reserved_ff  <= RST_RESERVED_SECTORS;
         fat_len_ff   <= RST_FAT_LENGTH_SECTORS;
         copies_ff    <= RST_FAT_COPIES;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_SECTOR_BYTES_LOG2:    sb_log2_ff  <= csr_wdata[3:0];
               REG_CLUSTER_SECTORS_LOG2: cs_log2_ff  <= csr_wdata[2:0];
               REG_RESERVED_SECTORS:     reserved_ff <= csr_wdata[15:0];
               REG_FAT_LENGTH_SECTORS:   fat_len_ff  <= csr_wdata;
               REG_FAT_COPIES:           copies_ff   <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      flen_ff       <= flen_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      remain_ff     <= remain_in;
      off_ff        <= off_in;
      cls_ff        <= cls_in;
      skip_ff       <= skip_in;
      seg_cnt_ff    <= seg_cnt_in;
      data_start_ff <= data_start_in;
      pend_sec_ff   <= pend_sec_in;
      pend_off_ff   <= pend_off_in;
      pend_len_ff   <= pend_len_in;
      pend_sts_ff   <= pend_sts_in;
      pend_last_ff  <= pend_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/fcrs_checker.sv -----
// fcrs_checker: port-level checks on the segmenter result channel, bound to the top level
// depends on fcrs_pkg and fat32_chain_read_segmenter_top
`timescale 1ns / 1ps

module fcrs_checker
   import fcrs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic [31:0] sec;
   logic [18:0] off;
   logic [19:0] len;
   logic [1:0]  sts;

   assign sec = rsp_tdata[RS_SEC_LO +: 32];
   assign off = rsp_tdata[RS_OFF_LO +: 19];
   assign len = rsp_tdata[RS_LEN_LO +: 20];
   assign sts = rsp_tdata[RS_STS_LO +: 2];

   // error or limit status only on the closing segment
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (sts != STATUS_OK) |-> rsp_tlast)
      else $error("non-ok status on a non-final segment");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (sts == STATUS_OK || sts == STATUS_CHAIN_END || sts == STATUS_SEG_LIMIT))
      else $error("undefined status code");

   // empty segment only as the single result of an empty or failed request
   a_empty_seg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (len == '0) |-> rsp_tlast && (sec == '0) && (off == '0))
      else $error("zero-length segment with address or not final");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind fat32_chain_read_segmenter_top fcrs_checker u_fcrs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
